>>> sv/mbrtu_pkg.sv
package mbrtu_pkg;

    localparam int RX_BUFFER_BYTES_DEF = 256;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0]  MAX_DEVICE = 8'd247;
    localparam logic [15:0] MAX_COILS  = 16'h07B0;
    localparam logic [15:0] MAX_REGS   = 16'h0078;
    localparam logic [7:0]  FN_WR_COILS = 8'd15;
    localparam logic [7:0]  FN_WR_REGS  = 8'd16;
    localparam logic [15:0] CRC_POLY    = 16'hA001;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;

    typedef enum logic [1:0] {
        MODE_HEADER  = 2'd0,
        MODE_PAYLOAD = 2'd1,
        MODE_RX      = 2'd2,
        MODE_READ    = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_FN   = 3'd1,
        ST_BAD_DEV  = 3'd2,
        ST_BAD_CNT  = 3'd3,
        ST_SHORT    = 3'd4,
        ST_CRC      = 3'd5,
        ST_MISMATCH = 3'd6,
        ST_EXCEPT   = 3'd7
    } t_status;

    // One classified input transaction as it travels from front to back.
    typedef struct packed {
        t_mode       mode;
        t_status     check;
        logic [7:0]  function_code;
        logic [7:0]  device_address;
        logic [15:0] start_address;
        logic [15:0] quantity_or_value;
        logic [15:0] payload_word;
        logic [7:0]  rx_byte;
        logic        frame_end;
        logic [7:0]  read_index;
    } t_cmd;

    function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] v;
        v = c ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (v[0]) begin
                v = (v >> 1) ^ CRC_POLY;
            end else begin
                v = v >> 1;
            end
        end
        return v;
    endfunction

endpackage

>>> sv/mbrtu_front.sv
module mbrtu_front
    import mbrtu_pkg::*;
(
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [79:0] i_data,
    input  logic        i_frame_end,
    input  logic        i_full,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic [7:0]  fn;
    logic [7:0]  dev;
    logic [15:0] qty;
    t_status     chk;

    assign fn  = i_data[7:0];
    assign dev = i_data[15:8];
    assign qty = i_data[47:32];

    // Request checks in priority order: function, device, then write counts.
    always_comb begin
        chk = ST_OK;
        if (!((fn >= 8'd1 && fn <= 8'd6) || fn == FN_WR_COILS || fn == FN_WR_REGS)) begin
            chk = ST_BAD_FN;
        end else if (dev > MAX_DEVICE) begin
            chk = ST_BAD_DEV;
        end else if (fn == FN_WR_COILS && (qty == 16'd0 || qty > MAX_COILS)) begin
            chk = ST_BAD_CNT;
        end else if (fn == FN_WR_REGS && (qty == 16'd0 || qty > MAX_REGS)) begin
            chk = ST_BAD_CNT;
        end
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_cmd.mode              = t_mode'(i_mode);
        o_cmd.check             = (t_mode'(i_mode) == MODE_HEADER) ? chk : ST_OK;
        o_cmd.function_code     = fn;
        o_cmd.device_address    = dev;
        o_cmd.start_address     = i_data[31:16];
        o_cmd.quantity_or_value = qty;
        o_cmd.payload_word      = i_data[63:48];
        o_cmd.rx_byte           = i_data[71:64];
        o_cmd.frame_end         = i_frame_end;
        o_cmd.read_index        = i_data[79:72];
    end

endmodule

>>> sv/mbrtu_queue.sv
module mbrtu_queue
    import mbrtu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

>>> sv/mbrtu_back.sv
module mbrtu_back
    import mbrtu_pkg::*;
#(
    parameter int RX_BUFFER_BYTES = RX_BUFFER_BYTES_DEF
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_data,
    output logic        o_last
);

    localparam int AW = (RX_BUFFER_BYTES > 1) ? $clog2(RX_BUFFER_BYTES) : 1;

    typedef enum logic [14:0] {
        S_IDLE = 15'b000000000000001,
        S_DISP = 15'b000000000000010,
        S_HDR  = 15'b000000000000100,
        S_CRCL = 15'b000000000001000,
        S_CRCH = 15'b000000000010000,
        S_PAY  = 15'b000000000100000,
        S_CA   = 15'b000000001000000,
        S_CB   = 15'b000000010000000,
        S_TA   = 15'b000000100000000,
        S_TB   = 15'b000001000000000,
        S_EVAL = 15'b000010000000000,
        S_PA   = 15'b000100000000000,
        S_PB   = 15'b001000000000000,
        S_STAT = 15'b010000000000000,
        S_RDB  = 15'b100000000000000
    } t_state;

    t_state      r_state, n_state;
    t_cmd        r_cmd, n_cmd;
    logic [7:0]  r_pdev, n_pdev;
    logic [7:0]  r_pfn, n_pfn;
    logic [31:0] r_echo, n_echo;
    logic        r_listen, n_listen;
    logic [10:0] r_prem, n_prem;
    logic [2:0]  r_crem, n_crem;
    logic [15:0] r_crc, n_crc;
    logic        r_skip, n_skip;
    logic [8:0]  r_rxcnt, n_rxcnt;
    logic [8:0]  r_step, n_step;
    logic [15:0] r_ccrc, n_ccrc;
    t_status     r_st, n_st;
    logic [7:0]  r_exc, n_exc;
    logic [7:0]  r_cnt, n_cnt;
    logic        r_regs, n_regs;
    logic        r_fromhdr, n_fromhdr;
    logic [7:0]  r_rxh [8];

    logic [7:0]  r_rxmem [RX_BUFFER_BYTES];
    logic [7:0]  r_saved [256];
    logic [7:0]  r_mrd;
    logic [7:0]  r_srd;

    logic        r_o_valid;
    logic [31:0] r_o_data;
    logic        r_o_last;

    logic        free;
    logic        emit;
    logic        e_txv, e_txl, e_sv, e_last;
    logic [7:0]  e_txb, e_exc, e_rd;
    t_status     e_st;

    logic [9:0]  rd_addr;
    logic        rx_we;
    logic        sv_we;
    logic [7:0]  sv_addr;

    logic        multi;
    logic [7:0]  bc;
    logic [7:0]  hb;
    logic [7:0]  coil_b;
    logic [7:0]  fc;
    logic        take;
    logic [8:0]  rxcnt_new;
    logic        skip_new;

    assign free    = !r_o_valid || i_ready;
    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;
    assign o_last  = r_o_last;
    assign o_pop   = (r_state == S_IDLE) && !i_empty;

    assign multi = (r_cmd.function_code == FN_WR_COILS) || (r_cmd.function_code == FN_WR_REGS);
    assign bc = (r_cmd.function_code == FN_WR_COILS)
              ? 8'(({1'b0, r_cmd.quantity_or_value} + 17'd7) >> 3)
              : 8'({r_cmd.quantity_or_value, 1'b0});
    assign fc = r_rxh[1];

    always_comb begin
        case (r_step[2:0])
            3'd0:    hb = r_cmd.device_address;
            3'd1:    hb = r_cmd.function_code;
            3'd2:    hb = r_cmd.start_address[15:8];
            3'd3:    hb = r_cmd.start_address[7:0];
            3'd4:    hb = r_cmd.quantity_or_value[15:8];
            3'd5:    hb = r_cmd.quantity_or_value[7:0];
            default: hb = bc;
        endcase
    end

    // The final coil byte keeps only the coils that the count covers.
    assign coil_b = (r_prem == 11'd1 && r_crem != 3'd0)
                  ? (r_cmd.payload_word[7:0] & ~(8'hFF << r_crem))
                  : r_cmd.payload_word[7:0];

    always_comb begin
        skip_new  = r_skip;
        rxcnt_new = r_rxcnt;
        rx_we     = 1'b0;
        if (!r_skip) begin
            if (r_rxcnt == 9'd0 && r_cmd.rx_byte != r_pdev) begin
                skip_new = 1'b1;
            end else if (r_rxcnt < 9'(RX_BUFFER_BYTES)) begin
                rx_we     = (r_state == S_DISP) && (r_cmd.mode == MODE_RX);
                rxcnt_new = r_rxcnt + 9'd1;
            end
        end
        take = r_listen && !skip_new && rxcnt_new != 9'd0;
    end

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_pdev    = r_pdev;
        n_pfn     = r_pfn;
        n_echo    = r_echo;
        n_listen  = r_listen;
        n_prem    = r_prem;
        n_crem    = r_crem;
        n_crc     = r_crc;
        n_skip    = r_skip;
        n_rxcnt   = r_rxcnt;
        n_step    = r_step;
        n_ccrc    = r_ccrc;
        n_st      = r_st;
        n_exc     = r_exc;
        n_cnt     = r_cnt;
        n_regs    = r_regs;
        n_fromhdr = r_fromhdr;
        emit      = 1'b0;
        e_txv     = 1'b0;
        e_txb     = 8'd0;
        e_txl     = 1'b0;
        e_sv      = 1'b0;
        e_st      = ST_OK;
        e_exc     = 8'd0;
        e_rd      = 8'd0;
        e_last    = 1'b0;
        rd_addr   = 10'd0;
        sv_we     = 1'b0;
        sv_addr   = r_step[7:0];

        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    n_cmd   = i_cmd;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                case (r_cmd.mode)
                    MODE_HEADER: begin
                        if (r_cmd.check != ST_OK) begin
                            emit   = 1'b1;
                            e_sv   = 1'b1;
                            e_st   = r_cmd.check;
                            e_last = 1'b1;
                            if (free) begin
                                n_state = S_IDLE;
                            end
                        end else begin
                            n_pdev    = r_cmd.device_address;
                            n_pfn     = r_cmd.function_code;
                            n_echo    = {r_cmd.start_address, r_cmd.quantity_or_value};
                            n_listen  = 1'b0;
                            n_rxcnt   = 9'd0;
                            n_skip    = 1'b0;
                            n_crc     = CRC_INIT;
                            n_step    = 9'd0;
                            n_fromhdr = 1'b1;
                            if (r_cmd.function_code == FN_WR_COILS) begin
                                n_prem = 11'(bc);
                                n_crem = r_cmd.quantity_or_value[2:0];
                            end else if (r_cmd.function_code == FN_WR_REGS) begin
                                n_prem = r_cmd.quantity_or_value[10:0];
                                n_crem = 3'd0;
                            end else begin
                                n_prem = 11'd0;
                                n_crem = 3'd0;
                            end
                            n_state = S_HDR;
                        end
                    end
                    MODE_PAYLOAD: begin
                        n_step    = 9'd0;
                        n_fromhdr = 1'b0;
                        n_state   = (r_prem == 11'd0) ? S_IDLE : S_PAY;
                    end
                    MODE_RX: begin
                        n_skip  = skip_new;
                        n_rxcnt = rxcnt_new;
                        n_state = S_IDLE;
                        if (r_cmd.frame_end) begin
                            if (take) begin
                                n_exc = 8'd0;
                                if (rxcnt_new < 9'd4) begin
                                    n_st    = ST_SHORT;
                                    n_state = S_STAT;
                                end else begin
                                    n_ccrc  = CRC_INIT;
                                    n_step  = 9'd0;
                                    n_state = S_CA;
                                end
                            end else begin
                                n_rxcnt = 9'd0;
                                n_skip  = 1'b0;
                            end
                        end
                    end
                    default: begin
                        n_state = S_RDB;
                    end
                endcase
            end
            S_HDR: begin
                emit  = 1'b1;
                e_txv = 1'b1;
                e_txb = hb;
                if (multi && r_step == 9'd6) begin
                    e_sv   = 1'b1;
                    e_last = 1'b1;
                end
                if (free) begin
                    n_crc = crc_step(r_crc, hb);
                    if (multi && r_step == 9'd6) begin
                        n_state = S_IDLE;
                    end else if (!multi && r_step == 9'd5) begin
                        n_state = S_CRCL;
                    end else begin
                        n_step = r_step + 9'd1;
                    end
                end
            end
            S_PAY: begin
                emit  = 1'b1;
                e_txv = 1'b1;
                if (r_pfn == FN_WR_REGS && r_step == 9'd0) begin
                    e_txb = r_cmd.payload_word[15:8];
                    if (free) begin
                        n_crc  = crc_step(r_crc, e_txb);
                        n_step = 9'd1;
                    end
                end else begin
                    e_txb  = (r_pfn == FN_WR_REGS) ? r_cmd.payload_word[7:0] : coil_b;
                    e_last = (r_prem != 11'd1);
                    if (free) begin
                        n_crc   = crc_step(r_crc, e_txb);
                        n_prem  = r_prem - 11'd1;
                        n_state = (r_prem == 11'd1) ? S_CRCL : S_IDLE;
                    end
                end
            end
            S_CRCL: begin
                emit  = 1'b1;
                e_txv = 1'b1;
                e_txb = r_crc[7:0];
                if (free) begin
                    n_state = S_CRCH;
                end
            end
            S_CRCH: begin
                emit   = 1'b1;
                e_txv  = 1'b1;
                e_txb  = r_crc[15:8];
                e_txl  = 1'b1;
                e_sv   = r_fromhdr;
                e_last = 1'b1;
                if (free) begin
                    n_listen = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            // Reply CRC runs over all bytes but the two CRC bytes, one per read.
            S_CA: begin
                rd_addr = {1'b0, r_step};
                n_state = S_CB;
            end
            S_CB: begin
                n_ccrc = crc_step(r_ccrc, r_mrd);
                n_step = r_step + 9'd1;
                if ({1'b0, r_step} + 10'd3 < {1'b0, r_rxcnt}) begin
                    n_state = S_CA;
                end else begin
                    n_step  = 9'd0;
                    n_state = S_TA;
                end
            end
            S_TA: begin
                rd_addr = {1'b0, r_rxcnt} - 10'd2 + {1'b0, r_step};
                n_state = S_TB;
            end
            S_TB: begin
                if (r_mrd != (r_step[0] ? r_ccrc[15:8] : r_ccrc[7:0])) begin
                    n_st    = ST_CRC;
                    n_state = S_STAT;
                end else if (r_step[0]) begin
                    n_state = S_EVAL;
                end else begin
                    n_step  = 9'd1;
                    n_state = S_TA;
                end
            end
            S_EVAL: begin
                n_state = S_STAT;
                n_step  = 9'd0;
                n_regs  = (fc > 8'd2);
                n_cnt   = (fc > 8'd2) ? {r_rxh[2][7:1], 1'b0} : r_rxh[2];
                if (fc[7]) begin
                    if ({1'b0, fc[6:0]} != r_pfn) begin
                        n_st = ST_MISMATCH;
                    end else if (r_rxcnt != 9'd5) begin
                        n_st = ST_SHORT;
                    end else begin
                        n_exc = r_rxh[2];
                        n_st  = ST_EXCEPT;
                    end
                end else if (fc != r_pfn) begin
                    n_st = ST_MISMATCH;
                end else if (fc <= 8'd4) begin
                    if ({1'b0, r_rxcnt} != {2'b00, r_rxh[2]} + 10'd5) begin
                        n_st = ST_SHORT;
                    end else begin
                        n_st = ST_OK;
                        if (((fc > 8'd2) ? r_rxh[2][7:1] : r_rxh[2][7:0]) != '0) begin
                            n_state = S_PA;
                        end
                    end
                end else if (r_rxcnt != 9'd8) begin
                    n_st = ST_SHORT;
                end else if ({r_rxh[2], r_rxh[3], r_rxh[4], r_rxh[5]} != r_echo) begin
                    n_st = ST_MISMATCH;
                end else begin
                    n_st = ST_OK;
                end
            end
            // Register data is saved with each byte pair swapped.
            S_PA: begin
                rd_addr = 10'd3 + {1'b0, r_step[8:1], r_step[0] ^ r_regs};
                n_state = S_PB;
            end
            S_PB: begin
                sv_we  = 1'b1;
                n_step = r_step + 9'd1;
                if (r_step + 9'd1 == {1'b0, r_cnt}) begin
                    n_state = S_STAT;
                end else begin
                    n_state = S_PA;
                end
            end
            S_STAT: begin
                emit   = 1'b1;
                e_sv   = 1'b1;
                e_st   = r_st;
                e_exc  = r_exc;
                e_last = 1'b1;
                if (free) begin
                    n_rxcnt = 9'd0;
                    n_skip  = 1'b0;
                    if (r_st == ST_OK) begin
                        n_listen = 1'b0;
                    end
                    n_state = S_IDLE;
                end
            end
            S_RDB: begin
                emit   = 1'b1;
                e_rd   = r_srd;
                e_last = 1'b1;
                if (free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pdev    <= 8'd0;
            r_pfn     <= 8'd0;
            r_echo    <= 32'd0;
            r_listen  <= 1'b0;
            r_prem    <= 11'd0;
            r_crem    <= 3'd0;
            r_crc     <= CRC_INIT;
            r_skip    <= 1'b0;
            r_rxcnt   <= 9'd0;
            r_o_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pdev   <= n_pdev;
            r_pfn    <= n_pfn;
            r_echo   <= n_echo;
            r_listen <= n_listen;
            r_prem   <= n_prem;
            r_crem   <= n_crem;
            r_crc    <= n_crc;
            r_skip   <= n_skip;
            r_rxcnt  <= n_rxcnt;
            if (free) begin
                r_o_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_step    <= n_step;
        r_ccrc    <= n_ccrc;
        r_st      <= n_st;
        r_exc     <= n_exc;
        r_cnt     <= n_cnt;
        r_regs    <= n_regs;
        r_fromhdr <= n_fromhdr;
        if (free && emit) begin
            r_o_data <= {2'b00, e_rd, e_exc, e_st, e_sv, e_txl, e_txb, e_txv};
            r_o_last <= e_last;
        end
        if (rx_we && r_rxcnt < 9'd8) begin
            r_rxh[r_rxcnt[2:0]] <= r_cmd.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_we) begin
            r_rxmem[r_rxcnt[AW-1:0]] <= r_cmd.rx_byte;
        end
        r_mrd <= r_rxmem[rd_addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (sv_we) begin
            r_saved[sv_addr] <= r_mrd;
        end
        r_srd <= r_saved[r_cmd.read_index];
    end

endmodule

>>> sv/modbus_rtu_master_transaction_top.sv
// Modbus RTU master. Input transactions carry a request header, a write
// payload element, a received line byte or a read-back index, chosen by
// s_axis_tuser; each gives zero or more result transactions, the final one
// marked by m_axis_tlast. A front stage checks requests and a two-entry queue
// feeds the back end, which takes a new transaction only once it is through
// with the last and emits the frame bytes with a bytewise CRC, holding each
// while m_axis_tready is low. A read or single-write request gives its six
// header bytes and the two CRC bytes, a write-multiple request its header
// and byte count, a register payload element two bytes and a coil payload
// element one, with the two CRC bytes after the last payload element. When a
// reply frame closes, the back end reads the reply buffer byte by byte for
// the CRC and again for the copy into saved data.
module modbus_rtu_master_transaction_top
    import mbrtu_pkg::*;
#(
    parameter int RX_BUFFER_BYTES = RX_BUFFER_BYTES_DEF
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // function_code, device_address, start_address, quantity_or_value,
    // payload_word, rx_byte, read_index
    input  logic [79:0] s_axis_tdata,
    // mode
    input  logic [1:0]  s_axis_tuser,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tx_valid, tx_byte, tx_last, status_valid, status, exception_code,
    // read_byte, two zero bits
    output logic [31:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    logic push;
    logic full;
    logic pop;
    logic empty;
    t_cmd fcmd;
    t_cmd qcmd;

    mbrtu_front u_front (
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_mode      (s_axis_tuser),
        .i_data      (s_axis_tdata),
        .i_frame_end (s_axis_tlast),
        .i_full      (full),
        .o_push      (push),
        .o_cmd       (fcmd)
    );

    mbrtu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (fcmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_cmd   (qcmd)
    );

    mbrtu_back #(
        .RX_BUFFER_BYTES (RX_BUFFER_BYTES)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_cmd   (qcmd),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

endmodule

>>> dv/tb_modbus_rtu_master_transaction_top.sv
`timescale 1ns / 100ps

module tb_modbus_rtu_master_transaction_top;
    import mbrtu_pkg::*;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       tx_last;
        logic       status_valid;
        logic [2:0] status;
        logic [7:0] exception_code;
        logic [7:0] read_byte;
        logic       last;
    } t_reply;

    class modbus_scoreboard;
        t_reply      expected_q[$];
        int          mismatches;
        logic [7:0]  dev_p;
        logic [7:0]  fn_p;
        logic [7:0]  echo_p [4];
        bit          listening;
        int          payload_left;
        int          coil_rem;
        logic [15:0] crc_acc;
        bit          skipping;
        int          rx_len;
        logic [7:0]  rx_buf [256];
        logic [7:0]  saved [256];

        function new();
            dev_p = 0;
            fn_p = 0;
            foreach (echo_p[i]) echo_p[i] = 0;
            listening = 0;
            payload_left = 0;
            coil_rem = 0;
            crc_acc = 16'hFFFF;
            skipping = 0;
            rx_len = 0;
            mismatches = 0;
            foreach (saved[i]) saved[i] = 0;
            foreach (rx_buf[i]) rx_buf[i] = 0;
        endfunction

        function logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
            c = c ^ {8'h00, b};
            for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
            return c;
        endfunction

        function void push(bit tv, logic [7:0] tb, bit tl, bit sv, logic [2:0] st,
                           logic [7:0] ex, logic [7:0] rd);
            t_reply r;
            r = '{tv, tb, tl, sv, st, ex, rd, 1'b0};
            expected_q.push_back(r);
        endfunction

        function void send_byte(logic [7:0] b);
            crc_acc = crc_byte(crc_acc, b);
            push(1, b, 0, 0, 0, 0, 0);
        endfunction

        function void send_crc();
            push(1, crc_acc[7:0], 0, 0, 0, 0, 0);
            push(1, crc_acc[15:8], 1, 0, 0, 0, 0);
            listening = 1;
        endfunction

        function logic [2:0] judge_reply(output logic [7:0] exc);
            logic [15:0] c;
            logic [7:0]  fc;
            int          bc;
            c = 16'hFFFF;
            exc = 0;
            if (rx_len < 4) return ST_SHORT;
            for (int i = 0; i + 2 < rx_len; i++) c = crc_byte(c, rx_buf[i]);
            if (rx_buf[rx_len-2] != c[7:0] || rx_buf[rx_len-1] != c[15:8]) return ST_CRC;
            fc = rx_buf[1];
            if (fc[7]) begin
                if ({1'b0, fc[6:0]} != fn_p) return ST_MISMATCH;
                if (rx_len != 5) return ST_SHORT;
                exc = rx_buf[2];
                return ST_EXCEPT;
            end
            if (fc != fn_p) return ST_MISMATCH;
            if (fc <= 4) begin
                bc = rx_buf[2];
                if (rx_len != bc + 5) return ST_SHORT;
                if (fc <= 2) begin
                    for (int i = 0; i < bc; i++) saved[i] = rx_buf[3+i];
                end else begin
                    for (int i = 0; i + 1 < bc; i += 2) begin
                        saved[i] = rx_buf[4+i];
                        saved[i+1] = rx_buf[3+i];
                    end
                end
            end else begin
                if (rx_len != 8) return ST_SHORT;
                for (int i = 0; i < 4; i++) if (rx_buf[2+i] != echo_p[i]) return ST_MISMATCH;
            end
            listening = 0;
            return ST_OK;
        endfunction

        // Works out the results of one accepted input transaction.
        function void note_input(t_mode m, logic [79:0] d, bit fe);
            logic [7:0]  f, dv, rb, idx, ex;
            logic [15:0] sa, q, w;
            logic [2:0]  st;
            int          n0, bc;
            f = d[7:0]; dv = d[15:8]; sa = d[31:16]; q = d[47:32];
            w = d[63:48]; rb = d[71:64]; idx = d[79:72];
            n0 = expected_q.size();
            case (m)
                MODE_HEADER: begin
                    st = ST_OK;
                    if (!((f >= 1 && f <= 6) || f == 15 || f == 16)) st = ST_BAD_FN;
                    else if (dv > 247) st = ST_BAD_DEV;
                    else if (f == 15 && (q == 0 || q > 16'h07B0)) st = ST_BAD_CNT;
                    else if (f == 16 && (q == 0 || q > 16'h0078)) st = ST_BAD_CNT;
                    if (st != ST_OK) begin
                        push(0, 0, 0, 1, st, 0, 0);
                    end else begin
                        dev_p = dv; fn_p = f;
                        echo_p[0] = sa[15:8]; echo_p[1] = sa[7:0];
                        echo_p[2] = q[15:8]; echo_p[3] = q[7:0];
                        listening = 0; rx_len = 0; skipping = 0; crc_acc = 16'hFFFF;
                        send_byte(dv); send_byte(f);
                        for (int i = 0; i < 4; i++) send_byte(echo_p[i]);
                        if (f == 15 || f == 16) begin
                            bc = (f == 15) ? (q + 7) / 8 : q * 2;
                            payload_left = (f == 15) ? bc : q;
                            coil_rem = (f == 15) ? q % 8 : 0;
                            send_byte(bc[7:0]);
                        end else begin
                            payload_left = 0; coil_rem = 0;
                            send_crc();
                        end
                        expected_q[$].status_valid = 1;
                    end
                end
                MODE_PAYLOAD: begin
                    if (payload_left != 0) begin
                        if (fn_p == 16) begin
                            send_byte(w[15:8]); send_byte(w[7:0]);
                        end else begin
                            rb = w[7:0];
                            if (payload_left == 1 && coil_rem != 0)
                                rb = rb & ((8'd1 << coil_rem) - 8'd1);
                            send_byte(rb);
                        end
                        payload_left--;
                        if (payload_left == 0) send_crc();
                    end
                end
                MODE_RX: begin
                    if (!skipping) begin
                        if (rx_len == 0 && rb != dev_p) skipping = 1;
                        else if (rx_len < 256) begin
                            rx_buf[rx_len] = rb;
                            rx_len++;
                        end
                    end
                    if (fe) begin
                        if (listening && !skipping && rx_len > 0) begin
                            st = judge_reply(ex);
                            push(0, 0, 0, 1, st, ex, 0);
                        end
                        rx_len = 0; skipping = 0;
                    end
                end
                default: push(0, 0, 0, 0, 0, 0, saved[idx]);
            endcase
            if (expected_q.size() > n0) expected_q[$].last = 1;
        endfunction

        function void check_result(logic [31:0] d, logic tl);
            t_reply got, want;
            got = '{d[0], d[8:1], d[9], d[10], d[13:11], d[21:14], d[29:22], tl};
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            want = expected_q.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) $display("mismatch: expected %h actual %h", want, got);
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        s_axis_tlast = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;

    modbus_scoreboard sb;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   cycles = 0;
    logic [7:0] cur_dev = 1;

    always #2 i_clk = ~i_clk;

    modbus_rtu_master_transaction_top dut (.*);

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
    end

    always @(negedge i_clk) m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Called at a falling edge; tvalid stays high after the transaction so that
    // the next one can follow straight on.
    task automatic drive_item(t_mode m, logic [7:0] f, logic [7:0] dv, logic [15:0] sa,
                              logic [15:0] q, logic [15:0] w, logic [7:0] rb, bit fe,
                              logic [7:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= m;
        s_axis_tlast <= fe;
        s_axis_tdata <= {idx, rb, w, q, sa, dv, f};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_input(m, {idx, rb, w, q, sa, dv, f}, fe);
        @(negedge i_clk);
    endtask

    task automatic header(logic [7:0] f, logic [7:0] dv, logic [15:0] sa, logic [15:0] q);
        drive_item(MODE_HEADER, f, dv, sa, q, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic payload(logic [15:0] w);
        drive_item(MODE_PAYLOAD, $urandom, $urandom, $urandom, $urandom, w, $urandom,
                   $urandom, $urandom);
    endtask

    task automatic rx(logic [7:0] b, bit fe);
        drive_item(MODE_RX, $urandom, $urandom, $urandom, $urandom, $urandom, b, fe,
                   $urandom);
    endtask

    task automatic readback(logic [7:0] idx);
        drive_item(MODE_READ, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, idx);
    endtask

    // Sends a reply frame with a correct CRC unless corrupt is set.
    task automatic reply(logic [7:0] bytes[$], bit corrupt);
        logic [15:0] c;
        c = 16'hFFFF;
        foreach (bytes[i]) c = sb.crc_byte(c, bytes[i]);
        if (corrupt) c = c ^ (16'd1 << $urandom_range(15));
        bytes.push_back(c[7:0]);
        bytes.push_back(c[15:8]);
        foreach (bytes[i]) rx(bytes[i], i == bytes.size() - 1);
    endtask

    // One well-formed exchange: request, payload, then a reply that is mostly good.
    task automatic exchange();
        logic [7:0]  f, dv, bc;
        logic [15:0] sa, q;
        logic [7:0]  fr[$];
        int          n, k;
        int          fns[8] = '{1, 2, 3, 4, 5, 6, 15, 16};
        f = fns[$urandom_range(7)];
        dv = $urandom_range(247);
        sa = $urandom;
        case (f)
            15: q = $urandom_range(1, 40);
            16: q = $urandom_range(1, 6);
            5, 6: q = $urandom;
            default: q = $urandom_range(1, 16);
        endcase
        header(f, dv, sa, q);
        cur_dev = dv;
        if (f == 15) for (int i = 0; i < (q + 7) / 8; i++) payload($urandom);
        if (f == 16) for (int i = 0; i < q; i++) payload($urandom);
        k = $urandom_range(9);
        fr.push_back(dv);
        if (k == 0) begin
            fr.push_back(f | 8'h80);
            fr.push_back($urandom);
        end else if (f <= 4) begin
            n = (f <= 2) ? $urandom_range(1, 8) : $urandom_range(1, 8);
            fr.push_back(f);
            fr.push_back(n + ((k == 1) ? 1 : 0));
            for (int i = 0; i < n; i++) fr.push_back($urandom);
        end else begin
            fr.push_back((k == 1) ? (f ^ 8'h01) : f);
            fr.push_back(sa[15:8]); fr.push_back(sa[7:0]);
            fr.push_back(q[15:8]); fr.push_back((k == 2) ? ~q[7:0] : q[7:0]);
        end
        // A one-byte frame from another device, skipped before the reply.
        if ($urandom_range(9) == 0) rx(dv + 1, 1);
        reply(fr, k == 3);
        if (f <= 2 || (f <= 4 && k != 0)) begin
            bc = fr[2];
            if (k > 3 && bc > 0 && f <= 2)
                for (int i = 0; i < 3; i++) readback($urandom_range(bc - 1));
        end
        if ($urandom_range(7) == 0) rx($urandom, $urandom_range(1));
    endtask

    task automatic settle();
        s_axis_tvalid <= 0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (1200) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        sb = new();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        // Directed part: rejections, extremes, and each special case.
        header(8'd0, 8'd1, 16'h0000, 16'h0001);
        header(8'd255, 8'd1, 16'h0000, 16'h0001);
        header(8'd3, 8'd248, 16'hFFFF, 16'hFFFF);
        header(8'd15, 8'd1, 16'h0000, 16'h0000);
        header(8'd15, 8'd1, 16'h0000, 16'h07B1);
        header(8'd16, 8'd1, 16'h0000, 16'h0079);
        header(8'd16, 8'd1, 16'h0000, 16'h0000);
        payload(16'hFFFF);
        header(8'd15, 8'd247, 16'hFFFF, 16'd11);
        payload(16'hFFFF);
        payload(16'hFFFF);
        header(8'd16, 8'd0, 16'hA5A5, 16'd1);
        payload(16'hFFFF);
        header(8'd3, 8'd9, 16'h0000, 16'd2);
        rx(8'd8, 0);
        rx(8'd3, 1);
        reply('{8'd9, 8'd3, 8'd3, 8'h12, 8'h34, 8'h56}, 0);
        readback(8'd0);
        readback(8'd1);
        rx(8'd9, 0);
        rx(8'd3, 1);
        reply('{8'd9, 8'h83, 8'd2}, 0);
        settle();
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 20 : 65) : 0;
            recv_stall_pct = (ph == 2) ? 65 : ((ph == 3) ? 20 : 0);
            for (int i = 0; i < 2; i++) begin
                if ($urandom_range(5) == 0) begin
                    drive_item(t_mode'($urandom_range(3)), $urandom, $urandom, $urandom,
                               $urandom, $urandom, $urandom, $urandom_range(1), 8'd0);
                end
                exchange();
            end
            if (ph == 0) begin
                // Overlong frame from the pending device, then an unsolicited frame.
                for (int i = 0; i < 262; i++) rx((i == 0) ? cur_dev : $urandom, i == 261);
                reply('{cur_dev, 8'd5, 8'd0, 8'd0}, 0);
            end
            settle();
        end
        if (sb.mismatches == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        wait (cycles >= 400000);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
